// ===== rtl/core/btpa_pkg.sv =====
// ----------------------------------------------------------------------------
// btpa_pkg
// Shared types, codes and helpers for the buddy tree page allocator.
// ----------------------------------------------------------------------------
package btpa_pkg;

  localparam int LEAF_LG    = 12;
  localparam int LEAF_PAGES = 1 << LEAF_LG;
  localparam int NODE_AW    = LEAF_LG + 1;  // node index / memory address width
  localparam int CNT_W      = 13;           // node value and page counts
  localparam int OFF_W      = 12;
  localparam int LG_W       = 4;            // log2 of a page count (0..13)

  // action codes
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_INIT  = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;  // unused, changes nothing

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_TOOBIG  = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [CNT_W-1:0] page_count;
    logic [OFF_W-1:0] page_offset;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] block_offset;
    logic [CNT_W-1:0] avail_pages;
  } rslt_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,       // zero node, step index up
    OP_LOAD,      // take the input item
    OP_FAIL,      // set failure status by action
    OP_RD_SELF,   // read node
    OP_RD_KIDS,   // read both children
    OP_STEP_DOWN, // descend toward the left when it fits
    OP_MARK,      // write the block node, update count, move to parent
    OP_WR_UP,     // refresh node, move to parent
    OP_INIT_LEAF, // write one leaf, step index up
    OP_SET_TOP,   // point at the last internal node
    OP_WR_DEC,    // refresh node, step index down
    OP_SET_CNT,   // load count from usable pages
    OP_CAPTURE    // load the result register
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       no_space;
    logic       too_big;
    logic       more_down;
    logic       at_root;
    logic       idx_last;
  } dp_sts_t;

  // ceil(log2(n)), zero and one give zero
  function automatic logic [LG_W-1:0] ceil_lg(input logic [CNT_W-1:0] n);
    logic [LG_W-1:0] k;
    k = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if ((CNT_W'(1) << i) < n) k = LG_W'(i + 1);
    end
    return k;
  endfunction

  // position of the highest set bit (tree level of a node)
  function automatic logic [LG_W-1:0] msb_pos(input logic [NODE_AW-1:0] v);
    logic [LG_W-1:0] p;
    p = '0;
    for (int i = 0; i < NODE_AW; i++) begin
      if (v[i]) p = LG_W'(i);
    end
    return p;
  endfunction

endpackage

// ===== rtl/core/buddy_tree_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_tree_page_allocator
// Binary buddy page allocator over a heap-numbered tree held in memory.
// ----------------------------------------------------------------------------
//  channel   ports                            transfer
//  input     in_valid / in_ready / in_data    valid & ready at clk edge
//  result    out_valid / out_ready / out_data valid & ready at clk edge
//  config    cfg_we / cfg_wdata               cfg_we at clk edge
//
//  One item at a time. Initialize walks every leaf and then every internal
//  node. After reset a clearing pass over the whole tree memory runs
//  before the first item is taken. A result waiting in the output
//  register does not stop the next item from being accepted.
module buddy_tree_page_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  btpa_pkg::item_t             in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output btpa_pkg::rslt_t             out_data,
  input  logic                        cfg_we,
  input  logic [btpa_pkg::CNT_W-1:0]  cfg_wdata
);

  btpa_pkg::dp_cmd_t cmd;
  btpa_pkg::dp_sts_t sts;

  btpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  btpa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/btpa_dp.sv =====
// ----------------------------------------------------------------------------
// btpa_dp
// Tree memory, node index walker, counters and result register.
// ----------------------------------------------------------------------------
module btpa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  btpa_pkg::dp_cmd_t             cmd,
  output btpa_pkg::dp_sts_t             sts,
  input  btpa_pkg::item_t               in_data,
  input  logic                          cfg_we,
  input  logic [btpa_pkg::CNT_W-1:0]    cfg_wdata,
  output btpa_pkg::rslt_t               out_data
);

  localparam int AW = btpa_pkg::NODE_AW;
  localparam int CW = btpa_pkg::CNT_W;
  localparam int LW = btpa_pkg::LG_W;

  logic [CW-1:0]  mem [0:(1<<AW)-1];
  logic [CW-1:0]  rd_a_r, rd_b_r;
  logic [AW-1:0]  idx_r;
  logic [1:0]     act_r;
  logic [LW-1:0]  k_r;
  logic [CW:0]    n_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  usable_r;
  logic [1:0]     status_r;
  logic [btpa_pkg::OFF_W-1:0] block_r;
  btpa_pkg::rslt_t out_r;

  logic [CW-1:0]  usable_cl;
  logic [AW-1:0]  kid_a, kid_b;
  logic [LW-1:0]  lvl;
  logic [CW-1:0]  full, ref_val;
  logic [LW-1:0]  k_in;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [CW-1:0]  wdata;

  assign usable_cl = (usable_r > CW'(btpa_pkg::LEAF_PAGES)) ?
                     CW'(btpa_pkg::LEAF_PAGES) : usable_r;
  assign kid_a = {idx_r[AW-2:0], 1'b0};
  assign kid_b = {idx_r[AW-2:0], 1'b1};
  assign lvl   = btpa_pkg::msb_pos(idx_r);
  assign k_in  = btpa_pkg::ceil_lg(in_data.page_count);

  // refresh: double when both children are whole, else the larger one
  assign full    = CW'(btpa_pkg::LEAF_PAGES) >> (lvl + LW'(1));
  assign ref_val = (rd_a_r == rd_b_r && rd_b_r == full) ? {rd_b_r[CW-2:0], 1'b0} :
                   (rd_a_r > rd_b_r) ? rd_a_r : rd_b_r;

  // memory write selection
  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = '0;
    case (cmd.op)
      btpa_pkg::OP_CLR:       we = 1'b1;
      btpa_pkg::OP_MARK: begin
        we    = 1'b1;
        wdata = (act_r == btpa_pkg::ACT_ALLOC) ? '0 : n_r[CW-1:0];
      end
      btpa_pkg::OP_WR_UP,
      btpa_pkg::OP_WR_DEC: begin
        we    = 1'b1;
        wdata = ref_val;
      end
      btpa_pkg::OP_INIT_LEAF: begin
        we    = 1'b1;
        wdata = CW'({1'b0, idx_r[AW-2:0]} < usable_cl);
      end
      default: we = 1'b0;
    endcase
  end

  // tree memory, two registered read ports
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.op == btpa_pkg::OP_RD_SELF) rd_a_r <= mem[idx_r];
    if (cmd.op == btpa_pkg::OP_RD_KIDS) begin
      rd_a_r <= mem[kid_a];
      rd_b_r <= mem[kid_b];
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) usable_r <= CW'(btpa_pkg::LEAF_PAGES);
    else if (cfg_we) usable_r <= cfg_wdata;
  end

  // index walker and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
    end else begin
      case (cmd.op)
        btpa_pkg::OP_CLR,
        btpa_pkg::OP_INIT_LEAF: idx_r <= idx_r + AW'(1);
        btpa_pkg::OP_LOAD: begin
          case (in_data.action)
            btpa_pkg::ACT_ALLOC: idx_r <= AW'(1);
            btpa_pkg::ACT_FREE:  idx_r <= {1'b1, in_data.page_offset} >> k_in;
            default:             idx_r <= AW'(btpa_pkg::LEAF_PAGES);
          endcase
        end
        btpa_pkg::OP_STEP_DOWN:
          idx_r <= (CW'(rd_a_r) >= n_r[CW-1:0]) ? kid_a : kid_b;
        btpa_pkg::OP_MARK: begin
          idx_r <= idx_r >> 1;
          if (act_r == btpa_pkg::ACT_ALLOC) cnt_r <= cnt_r - n_r[CW-1:0];
          else                              cnt_r <= cnt_r + n_r[CW-1:0];
        end
        btpa_pkg::OP_WR_UP:  idx_r <= idx_r >> 1;
        btpa_pkg::OP_SET_TOP: idx_r <= AW'(btpa_pkg::LEAF_PAGES - 1);
        btpa_pkg::OP_WR_DEC: idx_r <= idx_r - AW'(1);
        btpa_pkg::OP_SET_CNT: cnt_r <= usable_cl;
        default: idx_r <= idx_r;
      endcase
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      btpa_pkg::OP_LOAD: begin
        act_r    <= in_data.action;
        k_r      <= k_in;
        n_r      <= (CW+1)'(1) << k_in;
        status_r <= btpa_pkg::ST_DONE;
        block_r  <= '0;
      end
      btpa_pkg::OP_FAIL:
        status_r <= (act_r == btpa_pkg::ACT_ALLOC) ? btpa_pkg::ST_NOSPACE :
                                                      btpa_pkg::ST_TOOBIG;
      btpa_pkg::OP_MARK:
        if (act_r == btpa_pkg::ACT_ALLOC)
          block_r <= btpa_pkg::OFF_W'(idx_r << k_r);
      btpa_pkg::OP_CAPTURE: begin
        out_r.status       <= status_r;
        out_r.block_offset <= block_r;
        out_r.avail_pages  <= cnt_r;
      end
      default: act_r <= act_r;
    endcase
  end

  assign out_data      = out_r;
  assign sts.act       = act_r;
  assign sts.no_space  = n_r > (CW+1)'(rd_a_r);
  assign sts.too_big   = k_r > LW'(btpa_pkg::LEAF_LG);
  assign sts.more_down = ({1'b0, lvl} + {1'b0, k_r}) < (LW+1)'(btpa_pkg::LEAF_LG);
  assign sts.at_root   = idx_r == AW'(1);
  assign sts.idx_last  = &idx_r;

endmodule

// ===== rtl/core/btpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// btpa_ctrl
// Sequencer: memory clear, allocate descent, climb, initialize sweeps.
// ----------------------------------------------------------------------------
module btpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output btpa_pkg::dp_cmd_t  cmd,
  input  btpa_pkg::dp_sts_t  sts
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_ROOT_RD, S_ROOT_CHK, S_DN_CHK, S_DN_RD,
    S_DN_STEP, S_MARK, S_CL_RD, S_CL_WR, S_IN_LEAF, S_IN_TOP, S_IN_RD,
    S_IN_WR, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  // init count is loaded on the first emit cycle
  logic   cnt_set_r, cnt_set_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and command
  always_comb begin
    state_nxt     = state_r;
    cmd.op        = btpa_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        cmd.op = btpa_pkg::OP_CLR;
        if (sts.idx_last) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        cmd.op    = btpa_pkg::OP_LOAD;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        case (sts.act)
          btpa_pkg::ACT_ALLOC: state_nxt = S_ROOT_RD;
          btpa_pkg::ACT_FREE: begin
            if (sts.too_big) begin
              cmd.op    = btpa_pkg::OP_FAIL;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_MARK;
            end
          end
          btpa_pkg::ACT_INIT: state_nxt = S_IN_LEAF;
          default:            state_nxt = S_EMIT;
        endcase
      end
      S_ROOT_RD: begin
        cmd.op    = btpa_pkg::OP_RD_SELF;
        state_nxt = S_ROOT_CHK;
      end
      S_ROOT_CHK: begin
        if (sts.no_space) begin
          cmd.op    = btpa_pkg::OP_FAIL;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DN_CHK;
        end
      end
      S_DN_CHK: state_nxt = sts.more_down ? S_DN_RD : S_MARK;
      S_DN_RD: begin
        cmd.op    = btpa_pkg::OP_RD_KIDS;
        state_nxt = S_DN_STEP;
      end
      S_DN_STEP: begin
        cmd.op    = btpa_pkg::OP_STEP_DOWN;
        state_nxt = S_DN_CHK;
      end
      S_MARK: begin
        cmd.op    = btpa_pkg::OP_MARK;
        state_nxt = sts.at_root ? S_EMIT : S_CL_RD;
      end
      S_CL_RD: begin
        cmd.op    = btpa_pkg::OP_RD_KIDS;
        state_nxt = S_CL_WR;
      end
      S_CL_WR: begin
        cmd.op    = btpa_pkg::OP_WR_UP;
        state_nxt = sts.at_root ? S_EMIT : S_CL_RD;
      end
      S_IN_LEAF: begin
        cmd.op = btpa_pkg::OP_INIT_LEAF;
        if (sts.idx_last) state_nxt = S_IN_TOP;
      end
      S_IN_TOP: begin
        cmd.op    = btpa_pkg::OP_SET_TOP;
        state_nxt = S_IN_RD;
      end
      S_IN_RD: begin
        cmd.op    = btpa_pkg::OP_RD_KIDS;
        state_nxt = S_IN_WR;
      end
      S_IN_WR: begin
        cmd.op = btpa_pkg::OP_WR_DEC;
        if (sts.at_root) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IN_RD;
        end
      end
      S_EMIT: begin
        if (sts.act == btpa_pkg::ACT_INIT) cmd.op = btpa_pkg::OP_SET_CNT;
        if (!out_valid_r || out_ready) begin
          // count load above is registered, so init emits on the next pass
          if (sts.act != btpa_pkg::ACT_INIT || cnt_set_r) begin
            cmd.op        = btpa_pkg::OP_CAPTURE;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cnt_set_nxt = (state_r == S_EMIT) && (state_nxt == S_EMIT);

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      cnt_set_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_set_r   <= cnt_set_nxt;
    end
  end

endmodule

// ===== rtl/core/btpa_chk.sv =====
// ----------------------------------------------------------------------------
// btpa_chk
// Port-level checks for the buddy tree page allocator.
// ----------------------------------------------------------------------------
module btpa_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input btpa_pkg::rslt_t out_data
);

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // status never carries the unused code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == btpa_pkg::ST_DONE ||
                   out_data.status == btpa_pkg::ST_NOSPACE ||
                   out_data.status == btpa_pkg::ST_TOOBIG))
    else $error("bad status code");

  // failed items report a zero offset
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != btpa_pkg::ST_DONE |-> out_data.block_offset == '0)
    else $error("nonzero offset on failure");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind buddy_tree_page_allocator btpa_chk u_btpa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
